// ----- hdl/bas_pkg.sv -----
// Shared widths, ring entry type and saturation helper of the altitude and speed estimator.
package bas_pkg;

   localparam int ALT_W   = 24;
   localparam int TIME_W  = 32;
   localparam int REL_W   = ALT_W + 1;
   localparam int DH_W    = REL_W + 1;
   localparam int PROD_W  = DH_W + 11;
   localparam int MAG_W   = PROD_W - 1;
   localparam int OUT_W   = 24;

   localparam logic signed [10:0] SPEED_SCALE = 11'sd1000;
   localparam logic [OUT_W-1:0] OUT_POS_MAX = 24'h7FFFFF;
   localparam logic [OUT_W-1:0] OUT_NEG_MIN = 24'h800000;

   typedef struct packed {
      logic signed [REL_W-1:0] alt_rel;
      logic [TIME_W-1:0]       stamp;
   } ring_entry_type;

   function automatic logic [OUT_W-1:0] sat_mag(input logic [MAG_W-1:0] mag, input logic neg);
      logic [MAG_W-1:0] neg_mag;
      logic [OUT_W-1:0] res;
      neg_mag = -mag;
      if (!neg && mag > {{(MAG_W-OUT_W){1'b0}}, OUT_POS_MAX}) begin
         res = OUT_POS_MAX;
      end else if (neg && mag > {{(MAG_W-OUT_W){1'b0}}, OUT_NEG_MIN}) begin
         res = OUT_NEG_MIN;
      end else if (neg) begin
         res = neg_mag[OUT_W-1:0];
      end else begin
         res = mag[OUT_W-1:0];
      end
      return res;
   endfunction

endpackage

// ----- hdl/bas_ring_mem.sv -----
// Sample ring memory: one write port, two registered read ports, per-entry valid bits.
module bas_ring_mem #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  bas_pkg::ring_entry_type wr_data,
   input  logic [AW-1:0]           rd_addr_a,
   input  logic [AW-1:0]           rd_addr_b,
   output bas_pkg::ring_entry_type rd_data_a,
   output bas_pkg::ring_entry_type rd_data_b
);
   import bas_pkg::*;

   ring_entry_type mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   ring_entry_type rd_a_ff;
   ring_entry_type rd_b_ff;
   logic rdv_a_ff;
   logic rdv_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rdv_a_ff <= 1'b0;
         rdv_b_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rdv_a_ff <= valid_ff[rd_addr_a];
         rdv_b_ff <= valid_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rdv_a_ff ? rd_a_ff : '0;
   assign rd_data_b = rdv_b_ff ? rd_b_ff : '0;

endmodule

// ----- hdl/bas_divider.sv -----
// Unsigned restoring divider, one quotient bit per cycle.
module bas_divider #(
   parameter int NUM_W = 36,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quo
);
   localparam int CW = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic [CW-1:0]    cnt_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   rem_shift;
   logic [DEN_W:0]   diff;
   logic [DEN_W-1:0] rem_in;
   logic [NUM_W-1:0] quo_in;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[NUM_W-1]};
      diff      = rem_shift - {1'b0, den_ff};
      rem_in    = diff[DEN_W] ? rem_shift[DEN_W-1:0] : diff[DEN_W-1:0];
      quo_in    = {quo_ff[NUM_W-2:0], ~diff[DEN_W]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(NUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

// ----- hdl/baro_altitude_speed_estimator_unit.sv -----
// Barometric altitude mean and vertical speed estimator, top level.
// Usage:
//   req channel: one word per barometer sample (altitude in cm, timestamp in ms).
//   rsp channel: one word per sample with the ring mean altitude and the
//     vertical speed, tuser flags a valid speed (time advanced since the oldest entry).
//   csr channel: writes the ground altitude, always ready; write only while idle.
// Each sample is read, updated and written back in a ring memory of DEPTH
// entries, then a bit-serial divider forms the speed (product over elapsed
// time) while a short reciprocal-multiply pipe forms the mean by DEPTH.
// A sample passes the read, multiply, divider start and divide states before
// its result is loaded into the result register; the speed divider sets how
// long the divide state lasts. req_tready is high only between samples, so a
// new sample waits until the last result is loaded, also behind a stall.
// The result register holds a finished word while rsp_tready is low, and
// the next sample may be accepted meanwhile; its result waits until the
// register is free. Reset empties the ring (all entries read as zero), sets
// the write slot and running sum to zero and clears the ground altitude.
module baro_altitude_speed_estimator_unit #(
   parameter int DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // [23:0] altitude_cm, [55:24] timestamp_ms
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // [23:0] mean_altitude_cm, [47:24] vertical_speed_cm_s
   output logic        rsp_tuser,  // [0] speed_valid
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_data
);
   import bas_pkg::*;

   localparam int AW    = $clog2(DEPTH);
   localparam int SUM_W = REL_W + $clog2(DEPTH);
   localparam logic [SUM_W-1:0] MEAN_RECIP = SUM_W'((64'd1 << SUM_W) / DEPTH);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_START = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]               state_ff;
   logic [2:0]               state_in;
   logic [ALT_W-1:0]         ground_ff;
   logic [AW-1:0]            wp_ff;
   logic [AW-1:0]            wp_next;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [REL_W-1:0]  rel_ff;
   logic signed [REL_W-1:0]  rel_in;
   logic [TIME_W-1:0]        t_ff;
   logic signed [DH_W-1:0]   dh_ff;
   logic [TIME_W-1:0]        dt_ff;
   logic                     dtv_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_abs;
   logic [SUM_W-1:0]         sum_abs;
   logic                     prod_neg;
   logic                     sum_neg;
   ring_entry_type           slot_old;
   ring_entry_type           oldest;
   ring_entry_type           wr_entry;
   logic                     div_start;
   logic                     spd_busy;
   logic [MAG_W-1:0]         spd_quo;
   logic [2*SUM_W-1:0]       mean_prod_ff;
   logic [SUM_W-1:0]         mean_est_ff;
   logic [SUM_W-1:0]         mean_back_ff;
   logic [SUM_W-1:0]         mean_rem;
   logic [SUM_W-1:0]         mean_quo_ff;
   logic                     rsp_load;
   logic                     rsp_tvalid_ff;
   logic [47:0]              rsp_tdata_ff;
   logic                     rsp_tuser_ff;
   logic [OUT_W-1:0]         mean_sat;
   logic [OUT_W-1:0]         spd_sat;

   assign wp_next  = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign wr_entry = '{alt_rel: rel_ff, stamp: t_ff};

   bas_ring_mem #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (state_ff == S_READ),
      .wr_addr  (wp_ff),
      .wr_data  (wr_entry),
      .rd_addr_a(wp_ff),
      .rd_addr_b(wp_next),
      .rd_data_a(slot_old),
      .rd_data_b(oldest)
   );

   assign rel_in = {req_tdata[ALT_W-1], req_tdata[ALT_W-1:0]} - {ground_ff[ALT_W-1], ground_ff};
   assign sum_in = sum_ff
                 - {{(SUM_W-REL_W){slot_old.alt_rel[REL_W-1]}}, slot_old.alt_rel}
                 + {{(SUM_W-REL_W){rel_ff[REL_W-1]}}, rel_ff};

   assign prod_neg  = prod_ff[PROD_W-1];
   assign sum_neg   = sum_ff[SUM_W-1];
   assign prod_abs  = prod_neg ? -prod_ff : prod_ff;
   assign sum_abs   = sum_neg ? -sum_ff : sum_ff;
   assign div_start = (state_ff == S_START);

   bas_divider #(
      .NUM_W(MAG_W),
      .DEN_W(TIME_W)
   ) u_spd_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (prod_abs[MAG_W-1:0]),
      .den  (dt_ff),
      .busy (spd_busy),
      .quo  (spd_quo)
   );

   // estimate, back-multiply, then correct the quotient by at most one
   assign mean_rem = sum_abs - mean_back_ff;

   always_ff @(posedge clock) begin
      mean_prod_ff <= sum_abs * MEAN_RECIP;
      mean_est_ff  <= mean_prod_ff[2*SUM_W-1:SUM_W];
      mean_back_ff <= mean_est_ff * SUM_W'(DEPTH);
      mean_quo_ff  <= (mean_rem >= SUM_W'(DEPTH)) ? mean_est_ff + 1'b1 : mean_est_ff;
   end

   assign mean_sat = sat_mag({{(MAG_W-SUM_W){1'b0}}, mean_quo_ff}, sum_neg);
   assign spd_sat  = dtv_ff ? sat_mag(spd_quo, prod_neg) : '0;
   assign rsp_load = (state_ff == S_OUT) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_READ;
            end
         end
         S_READ:  state_in = S_MUL;
         S_MUL:   state_in = S_START;
         S_START: state_in = S_DIV;
         S_DIV: begin
            if (!spd_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ground_ff     <= '0;
         wp_ff         <= '0;
         sum_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            ground_ff <= csr_data;
         end
         if (state_ff == S_READ) begin
            wp_ff  <= wp_next;
            sum_ff <= sum_in;
         end
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         rel_ff <= rel_in;
         t_ff   <= req_tdata[ALT_W+TIME_W-1:ALT_W];
      end
      if (state_ff == S_READ) begin
         dh_ff  <= {rel_ff[REL_W-1], rel_ff} - {oldest.alt_rel[REL_W-1], oldest.alt_rel};
         dt_ff  <= t_ff - oldest.stamp;
         dtv_ff <= t_ff > oldest.stamp;
      end
      if (state_ff == S_MUL) begin
         prod_ff <= dh_ff * SPEED_SCALE;
      end
      if (rsp_load) begin
         rsp_tdata_ff <= {spd_sat, mean_sat};
         rsp_tuser_ff <= dtv_ff;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign csr_ready  = 1'b1;

endmodule
